>>> rtl/core/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
// No dependencies; the interfaces, the top level and kmd_step import this package.
package kmd_pkg;

   localparam int ROW_W  = 3;
   localparam int COL_W  = 3;
   localparam int TIME_W = 32;
   localparam int DB_W   = 16;

   localparam logic [DB_W-1:0] DB_RESET = 16'd5;

   // One stored entry per key: last raw level, accepted level, change time.
   typedef struct packed {
      logic              last_raw;
      logic              stable_level;
      logic [TIME_W-1:0] change_time;
   } kmd_entry_type;

   // Outcome of one per-key update.
   typedef struct packed {
      kmd_entry_type entry;
      logic          level;
      logic          changed;
   } kmd_step_type;

endpackage

>>> rtl/core/kmd_req_if.sv
// Input channel of the key matrix debouncer: one sampled key per beat.
// Depends on kmd_pkg for the field widths.
interface kmd_req_if import kmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  key_row;
   logic [COL_W-1:0]  key_col;
   logic              raw_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, key_row, key_col, raw_level, now_ms, input ready);
   modport sink   (input valid, key_row, key_col, raw_level, now_ms, output ready);
endinterface

>>> rtl/core/kmd_rsp_if.sv
// Result channel of the key matrix debouncer: one debounced key per beat.
// Depends on kmd_pkg for the field widths.
interface kmd_rsp_if import kmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic             accepted_level;
   logic             level_changed;

   modport source (output valid, out_row, out_col, accepted_level, level_changed,
                   input ready);
   modport sink   (input valid, out_row, out_col, accepted_level, level_changed,
                   output ready);
endinterface

>>> rtl/core/key_matrix_debounce.sv
// Key matrix debouncer top level. An accepted input beat is registered in the working
// stage, then its result beat in the result register; throughput is one beat per cycle
// while the result channel does not stall, set by the single read-modify-write of the
// per-key state RAM with write-back forwarding. Synchronous reset clears all per-key
// state through per-key valid bits and loads debounce_ms with 5. Depends on kmd_pkg,
// kmd_req_if, kmd_rsp_if, kmd_ram and kmd_step.
module key_matrix_debounce import kmd_pkg::*; #(
   parameter int KEY_ROWS = 8,
   parameter int KEY_COLS = 8
) (
   input  logic            clock,
   input  logic            reset,
   kmd_req_if.sink         req_chan,
   kmd_rsp_if.source       rsp_chan,
   input  logic            csr_we,
   input  logic [DB_W-1:0] csr_wdata
);

   // Only rows and columns that the index fields can address hold state.
   localparam int ROWS_EFF  = (KEY_ROWS < (1 << ROW_W)) ? KEY_ROWS : (1 << ROW_W);
   localparam int COLS_EFF  = (KEY_COLS < (1 << COL_W)) ? KEY_COLS : (1 << COL_W);
   localparam int KEY_COUNT = ROWS_EFF * COLS_EFF;
   localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int LIN_W     = ROW_W + COL_W + 1;
   localparam int ENTRY_W   = $bits(kmd_entry_type);

   logic [DB_W-1:0]   db_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_hit_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_raw_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic [IDX_W-1:0]  s1_idx_ff;

   logic              wb_valid_ff, wb_valid_in;
   logic [IDX_W-1:0]  wb_idx_ff;
   kmd_entry_type     wb_entry_ff;

   logic [KEY_COUNT-1:0] valid_ff, valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_level_ff;
   logic              rsp_changed_ff;

   logic              rsp_free;
   logic              s1_adv;
   logic              req_acc;
   logic              req_hit;
   logic [LIN_W-1:0]  req_lin;
   logic [IDX_W-1:0]  req_idx;
   logic              wr_en;
   logic [ENTRY_W-1:0] rd_data;
   kmd_entry_type     cur_entry;
   kmd_step_type      step;

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign req_hit = ({1'b0, req_chan.key_row} < (ROW_W+1)'(ROWS_EFF))
                 && ({1'b0, req_chan.key_col} < (COL_W+1)'(COLS_EFF));
   assign req_lin = LIN_W'(req_chan.key_row) * LIN_W'(COLS_EFF)
                  + LIN_W'(req_chan.key_col);
   assign req_idx = req_lin[IDX_W-1:0];

   assign wr_en = s1_adv && s1_hit_ff;

   kmd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEY_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (step.entry),
      .rd_en   (req_acc),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   // The RAM read for this beat may have happened at the edge that stored the
   // previous write, so that write is forwarded from the write-back register.
   always_comb begin
      cur_entry = '0;
      if (s1_hit_ff) begin
         if (wb_valid_ff && (wb_idx_ff == s1_idx_ff)) begin
            cur_entry = wb_entry_ff;
         end else if (valid_ff[s1_idx_ff]) begin
            cur_entry = kmd_entry_type'(rd_data);
         end
      end
   end

   kmd_step u_step (
      .cur         (cur_entry),
      .raw_level   (s1_raw_ff),
      .now_ms      (s1_now_ff),
      .debounce_ms (db_ff),
      .result      (step)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      wb_valid_in  = wb_valid_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end
      if (wr_en) begin
         wb_valid_in         = 1'b1;
         valid_in[s1_idx_ff] = 1'b1;
      end
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff        <= DB_RESET;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            db_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         wb_valid_ff  <= wb_valid_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_hit_ff <= req_hit;
         s1_row_ff <= req_chan.key_row;
         s1_col_ff <= req_chan.key_col;
         s1_raw_ff <= req_chan.raw_level;
         s1_now_ff <= req_chan.now_ms;
         s1_idx_ff <= req_idx;
      end
      if (wr_en) begin
         wb_idx_ff   <= s1_idx_ff;
         wb_entry_ff <= step.entry;
      end
      if (s1_adv) begin
         rsp_row_ff     <= s1_row_ff;
         rsp_col_ff     <= s1_col_ff;
         rsp_level_ff   <= s1_hit_ff && step.level;
         rsp_changed_ff <= s1_hit_ff && step.changed;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_row        = rsp_row_ff;
   assign rsp_chan.out_col        = rsp_col_ff;
   assign rsp_chan.accepted_level = rsp_level_ff;
   assign rsp_chan.level_changed  = rsp_changed_ff;

   // A beat for a key outside the matrix reports a low, unchanged level.
   a_outside_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (({1'b0, rsp_row_ff} >= (ROW_W+1)'(ROWS_EFF))
                    || ({1'b0, rsp_col_ff} >= (COL_W+1)'(COLS_EFF)))
      |-> !rsp_level_ff && !rsp_changed_ff)
      else $error("key outside the matrix reported a level");

   // A beat held in the working stage is not lost while the result waits.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_free |=> s1_valid_ff && $stable(s1_idx_ff)
                                  && $stable(s1_now_ff))
      else $error("working stage overwritten during a stall");

   // Per-key valid bits only ever get set between resets.
   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      !reset |=> $countones(valid_ff) >= $past($countones(valid_ff)))
      else $error("per-key valid bit cleared without reset");

   // State is only written while a result is being produced.
   a_write_makes_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff && wb_valid_ff)
      else $error("state write without a result beat");

endmodule

>>> rtl/core/kmd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
module kmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/kmd_step.sv
// Per-key debounce update: compares the raw level with the stored entry
// and decides the new entry and accepted level. Depends on kmd_pkg.
module kmd_step import kmd_pkg::*; (
   input  kmd_entry_type     cur,
   input  logic              raw_level,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [DB_W-1:0]   debounce_ms,
   output kmd_step_type      result
);

   logic [TIME_W-1:0] elapsed;
   logic              settled;

   assign elapsed = now_ms - cur.change_time;
   assign settled = elapsed > {{(TIME_W-DB_W){1'b0}}, debounce_ms};

   always_comb begin
      result.entry   = cur;
      result.changed = 1'b0;
      if (cur.last_raw != raw_level) begin
         result.entry.last_raw    = raw_level;
         result.entry.change_time = now_ms;
      end else if (settled && (cur.stable_level != raw_level)) begin
         result.entry.stable_level = raw_level;
         result.changed            = 1'b1;
      end
      result.level = result.entry.stable_level;
   end

endmodule
